// ----- rtl/aubf_pkg.sv -----
// shared types, constants and unit type decoders for the access unit boundary finder
`default_nettype none
package aubf_pkg;

    localparam int HistBits = 48;
    localparam logic [HistBits-1:0] HistReset = {HistBits{1'b1}};
    localparam logic [31:0] StartCode = 32'h0000_0001;

    localparam int LenBits = 32;
    localparam int TypeBits = 5;

    // unit types of interest
    localparam logic [TypeBits-1:0] UnitSliceNonIdr = 5'd1;
    localparam logic [TypeBits-1:0] UnitSlicePartA = 5'd2;
    localparam logic [TypeBits-1:0] UnitPicHeader = 5'd3;
    localparam logic [TypeBits-1:0] UnitSliceIdr = 5'd4;
    localparam logic [TypeBits-1:0] UnitParamSeq = 5'd7;
    localparam logic [TypeBits-1:0] UnitParamPic = 5'd8;
    localparam logic [TypeBits-1:0] UnitSliceExt = 5'd14;
    localparam logic [TypeBits-1:0] UnitSliceLayer = 5'd17;
    localparam logic [TypeBits-1:0] UnitNone = 5'd0;

    // back distance from the newest header byte to the start code's first byte
    localparam int BoundaryBack = 5;

    localparam logic StatusBoundary = 1'b0;
    localparam logic StatusUnterminated = 1'b1;

    // result queue between front and back
    localparam int QueueDepth = 4;
    localparam int QueueAddrBits = $clog2(QueueDepth);
    localparam int QueueCntBits = QueueAddrBits + 1;

    typedef struct packed {
        logic                status;
        logic [LenBits-1:0]  frame_length;
        logic [TypeBits-1:0] unit_type;
        logic                last_of_run;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    function automatic logic is_slice(input logic [TypeBits-1:0] t);
        logic r;
        unique case (t) inside
            UnitSliceNonIdr, UnitSlicePartA, UnitSliceIdr, UnitSliceExt,
            UnitSliceLayer: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_start(input logic [TypeBits-1:0] t);
        logic r;
        unique case (t) inside
            UnitParamSeq, UnitParamPic, UnitPicHeader: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/aubf_front.sv -----
// front part: byte history, start code detection and result generation
`default_nettype none
module aubf_front #(
    parameter int PosBits = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_eos,
    output aubf_pkg::t_push      o_push
);

    localparam int ExtBits = (PosBits > aubf_pkg::LenBits) ? PosBits : aubf_pkg::LenBits;

    logic [aubf_pkg::HistBits-1:0] r_hist, n_hist;
    logic [PosBits-1:0] r_pos, n_pos;
    logic [PosBits-1:0] r_fstart, n_fstart;
    logic r_armed, n_armed;
    logic r_pending, n_pending;

    logic armed_eff;
    logic match;
    logic [aubf_pkg::TypeBits-1:0] utype;
    logic slice_hit, start_hit;
    logic [PosBits-1:0] pos_inc, boundary, len_unit, len_rest, fstart_eff;
    logic [ExtBits-1:0] ext_unit, ext_rest;
    aubf_pkg::t_result res_unit, res_rest;

    always_comb begin
        armed_eff = r_armed | (r_pending & (i_byte == 8'd0));
        n_hist = {r_hist[aubf_pkg::HistBits-9:0], i_byte};
        match = (n_hist[aubf_pkg::HistBits-1:16] == aubf_pkg::StartCode);
        utype = n_hist[aubf_pkg::TypeBits-1:0];
        slice_hit = match & aubf_pkg::is_slice(utype);
        start_hit = match & aubf_pkg::is_start(utype) & armed_eff;

        pos_inc = r_pos + PosBits'(1);
        boundary = r_pos - PosBits'(aubf_pkg::BoundaryBack);
        len_unit = boundary - r_fstart;
        fstart_eff = start_hit ? boundary : r_fstart;
        len_rest = pos_inc - fstart_eff;
        ext_unit = ExtBits'(len_unit);
        ext_rest = ExtBits'(len_rest);

        res_unit.status = aubf_pkg::StatusBoundary;
        res_unit.frame_length = ext_unit[aubf_pkg::LenBits-1:0];
        res_unit.unit_type = utype;
        res_unit.last_of_run = ~i_eos;

        res_rest.status = aubf_pkg::StatusUnterminated;
        res_rest.frame_length = ext_rest[aubf_pkg::LenBits-1:0];
        res_rest.unit_type = aubf_pkg::UnitNone;
        res_rest.last_of_run = 1'b1;

        o_push.count = i_valid ? ({1'b0, start_hit} + {1'b0, i_eos}) : 2'd0;
        o_push.first = start_hit ? res_unit : res_rest;
        o_push.second = res_rest;

        n_pos = pos_inc;
        n_fstart = fstart_eff;
        n_armed = start_hit ? 1'b0 : armed_eff;
        n_pending = slice_hit;
        if (i_eos) begin
            n_hist = aubf_pkg::HistReset;
            n_pos = '0;
            n_fstart = '0;
            n_armed = 1'b0;
            n_pending = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= aubf_pkg::HistReset;
            r_pos <= '0;
            r_fstart <= '0;
            r_armed <= 1'b0;
            r_pending <= 1'b0;
        end else if (i_valid) begin
            r_hist <= n_hist;
            r_pos <= n_pos;
            r_fstart <= n_fstart;
            r_armed <= n_armed;
            r_pending <= n_pending;
        end
    end

`ifndef SYNTHESIS
    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_eos |=> r_pos == '0 && !r_armed && !r_pending)
        else $error("state not cleared after last byte");
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.count != 2'd3)
        else $error("illegal push count");
`endif

endmodule
`default_nettype wire

// ----- rtl/aubf_queue.sv -----
// back part: result queue taking up to two results per cycle, delivering one
`default_nettype none
module aubf_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire aubf_pkg::t_push i_push,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output aubf_pkg::t_result    o_head
);

    aubf_pkg::t_result r_mem [aubf_pkg::QueueDepth];
    logic [aubf_pkg::QueueAddrBits-1:0] r_wp, r_rp;
    logic [aubf_pkg::QueueCntBits-1:0] r_count, n_count;
    logic [aubf_pkg::QueueAddrBits-1:0] wp_next;
    logic pop_ok;

    assign pop_ok = i_pop & (r_count != '0);
    assign wp_next = r_wp + aubf_pkg::QueueAddrBits'(1);
    assign n_count = r_count + aubf_pkg::QueueCntBits'(i_push.count)
                   - aubf_pkg::QueueCntBits'(pop_ok);

    // full leaves room for the two results one byte can cause
    assign o_full = (r_count > aubf_pkg::QueueCntBits'(aubf_pkg::QueueDepth - 2));
    assign o_empty = (r_count == '0);
    assign o_head = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wp] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wp_next] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_count <= '0;
        end else begin
            r_wp <= r_wp + aubf_pkg::QueueAddrBits'(i_push.count);
            if (pop_ok) begin
                r_rp <= r_rp + aubf_pkg::QueueAddrBits'(1);
            end
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= aubf_pkg::QueueCntBits'(aubf_pkg::QueueDepth))
        else $error("result queue overflow");
    a_room_for_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.count == 2'd2 |->
            r_count <= aubf_pkg::QueueCntBits'(aubf_pkg::QueueDepth - 2))
        else $error("pair pushed without room");
`endif

endmodule
`default_nettype wire

// ----- rtl/access_unit_boundary_finder.sv -----
// top level of the access unit boundary finder
`default_nettype none
// Scans an elementary stream one byte per transaction and reports access
// unit boundaries. A header is a 00 00 00 01 start code plus two header
// bytes; a slice unit (types 1, 2, 4, 14, 17) followed by a zero byte arms
// the finder, and the next parameter set or picture header unit (types 7,
// 8, 3) closes the access unit at the first byte of its start code,
// reporting its length (status 0) and the type of the new unit. On the byte
// flagged end_of_stream the bytes not yet reported come out as one status 1
// result and all state returns to reset, so a new stream may follow at once.
// One byte is taken each clock while full is low: the front part
// classifies the byte in the cycle it is accepted and writes zero, one or
// two results into a four-entry result queue; full rises while fewer than
// two entries are free. Results leave one per clock from the queue head
// while pop is high. Positions wrap at 2^POSITION_BITS.
module access_unit_boundary_finder #(
    parameter int POSITION_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte side
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_stream_byte,
    input  wire logic        i_end_of_stream,
    // result side
    output logic             empty,
    input  wire logic        pop,
    output logic             o_status,
    output logic [31:0]      o_frame_length,
    output logic [4:0]       o_unit_type,
    output logic             o_last_of_run
);

    // a byte transaction completes when push meets a queue with room for two
    logic accept;
    aubf_pkg::t_push push_bus;
    aubf_pkg::t_result head;

    assign accept = push & ~full;

    // front: history, header detection, length arithmetic
    aubf_front #(
        .PosBits (POSITION_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_byte  (i_stream_byte),
        .i_eos   (i_end_of_stream),
        .o_push  (push_bus)
    );

    // back: result queue, the head drives the result ports directly
    aubf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_bus),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    assign o_status = head.status;
    assign o_frame_length = head.frame_length;
    assign o_unit_type = head.unit_type;
    assign o_last_of_run = head.last_of_run;

`ifndef SYNTHESIS
    // the last byte of a stream always leaves a result waiting
    a_eos_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_end_of_stream |=> !empty)
        else $error("no result after last byte");
`endif

endmodule
`default_nettype wire
